### sv/scm_pkg.sv
// Shared types and constants for the square matrix multiply block.
// Holds operation codes, controller states, field widths and the MAC control word.
// No dependencies.
`timescale 1ns / 1ps

package scm_pkg;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int VALUE_W = 16;
   localparam int ACC_W   = 32;
   localparam int SIZE_W  = 7;
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 48;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // Control that travels alongside the memory read data into the MAC
   typedef struct packed {
      logic clear;     // zero the accumulator for a new entry
      logic rd_valid;  // read data of both memories is valid this cycle
      logic last;      // this read pair holds the final term
   } mac_ctl_type;

endpackage

### sv/scm_ram.sv
// Single-port-write, single-port-read synchronous memory for one matrix.
// Read data is registered. Uses no package.
`timescale 1ns / 1ps

module scm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/scm_mac.sv
// Multiply-accumulate datapath: registered 16x16 signed product, then 32-bit
// wrapping accumulate. Depends on scm_pkg for widths and the control struct.
`timescale 1ns / 1ps

module scm_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  scm_pkg::mac_ctl_type               ctl,
   input  logic signed [scm_pkg::VALUE_W-1:0] rd_a,
   input  logic signed [scm_pkg::VALUE_W-1:0] rd_b,
   output logic        [scm_pkg::ACC_W-1:0]   acc,
   output logic                               done
);
   import scm_pkg::*;

   logic signed [ACC_W-1:0] prod_in;
   logic signed [ACC_W-1:0] prod_ff;
   logic                    prod_valid_ff;
   logic                    prod_last_ff;
   logic [ACC_W-1:0]        acc_in;
   logic [ACC_W-1:0]        acc_ff;
   logic                    done_ff;

   assign prod_in = rd_a * rd_b;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         prod_last_ff  <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.rd_valid;
         prod_last_ff  <= ctl.rd_valid & ctl.last;
         done_ff       <= prod_valid_ff & prod_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

### sv/square_matrix_multiply.sv
// Square matrix multiply, one product entry per compute word: a load word
// is written into the A or B memory in the cycle it is accepted, and the
// block is ready again at the next cycle. A compute word for entry
// C[row][col] walks k = 0..N-1, reading A[row][k] and B[k][col] from the two
// matrix memories (one read port each) and feeding one multiply-accumulate
// per cycle, N being min(size register, MAX_SIZE). After the accept come N
// read issues, then the memory read, product and accumulate registers and
// the hand-off to the output register. The result sits in an output
// register, so the next word is accepted while it waits. Words with row or
// col not below N, and op 3, are dropped with no result. Memories are not
// cleared; an entry read before it was written returns whatever the memory
// holds.
// Depends on scm_pkg, scm_ram and scm_mac.
`timescale 1ns / 1ps

module square_matrix_multiply #(
   parameter int MAX_SIZE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // csr: size in use
   input  logic                          csr_wr_en,
   input  logic [scm_pkg::SIZE_W-1:0]    csr_wr_data,
   // req_tdata: op[1:0], row[7:2], col[13:8], value[29:14], zero pad[31:30]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [scm_pkg::REQ_W-1:0]     req_tdata,
   // rsp_tdata: out_row[5:0], out_col[11:6], entry_value[43:12], zero pad[47:44]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [scm_pkg::RSP_W-1:0]     rsp_tdata
);
   import scm_pkg::*;

   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW    = $clog2(MAX_SIZE + 1);
   localparam int CW    = (KW > SIZE_W) ? KW : SIZE_W;

   // request fields
   logic [OP_W-1:0]           req_op;
   logic [IDX_W-1:0]          req_row;
   logic [IDX_W-1:0]          req_col;
   logic [VALUE_W-1:0]        req_value;

   logic [SIZE_W-1:0]         size_ff;
   logic [CW-1:0]             size_cw;
   logic [CW-1:0]             n_cw;
   logic [KW-1:0]             n_eff;
   logic                      in_range;
   logic                      req_fire;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          row_ff, col_ff;
   logic [KW-1:0]             k_ff, k_in;
   logic                      issue;
   logic                      issue_last;
   logic                      rd_valid_ff;
   logic                      rd_last_ff;

   logic                      wr_a, wr_b;
   logic [AW-1:0]             wr_addr;
   logic [AW-1:0]             rd_addr_a, rd_addr_b;
   logic [VALUE_W-1:0]        rd_a, rd_b;

   mac_ctl_type               mac_ctl;
   logic [ACC_W-1:0]          acc;
   logic                      mac_done;

   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_row_ff, rsp_col_ff;
   logic [ACC_W-1:0]          rsp_value_ff;
   logic                      emit;

   assign req_op    = req_tdata[OP_W-1:0];
   assign req_row   = req_tdata[OP_W +: IDX_W];
   assign req_col   = req_tdata[OP_W+IDX_W +: IDX_W];
   assign req_value = req_tdata[OP_W+2*IDX_W +: VALUE_W];

   // clamp the size register to the memory dimension
   assign size_cw  = CW'(size_ff);
   assign n_cw     = (size_cw > CW'(MAX_SIZE)) ? CW'(MAX_SIZE) : size_cw;
   assign n_eff    = KW'(n_cw);
   assign in_range = (CW'(req_row) < n_cw) && (CW'(req_col) < n_cw);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   assign wr_a    = req_fire & in_range & (req_op == OP_LOAD_A);
   assign wr_b    = req_fire & in_range & (req_op == OP_LOAD_B);
   assign wr_addr = AW'(int'(req_row) * MAX_SIZE + int'(req_col));

   assign issue      = (state_ff == ST_RUN);
   assign issue_last = issue & (k_ff == n_eff - KW'(1));
   assign rd_addr_a  = AW'(int'(row_ff) * MAX_SIZE + int'(k_ff));
   assign rd_addr_b  = AW'(int'(k_ff) * MAX_SIZE + int'(col_ff));

   assign emit = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            k_in = '0;
            if (req_fire & in_range & (req_op == OP_COMPUTE)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            k_in = k_ff + KW'(1);
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_W'(MAX_SIZE > 64 ? 64 : MAX_SIZE);
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      rd_last_ff <= issue_last;
      if (req_fire) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (emit) begin
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_value_ff <= acc;
      end
   end

   scm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   scm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   assign mac_ctl.clear    = req_fire;
   assign mac_ctl.rd_valid = rd_valid_ff;
   assign mac_ctl.last     = rd_last_ff;

   scm_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .rd_a  (rd_a),
      .rd_b  (rd_b),
      .acc   (acc),
      .done  (mac_done)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - ACC_W - 2*IDX_W)'(0), rsp_value_ff, rsp_col_ff, rsp_row_ff};

endmodule

### sv/scm_check.sv
// Port-level checks for square_matrix_multiply, bound to the top level.
// Depends on scm_pkg widths only.
`timescale 1ns / 1ps

module scm_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [scm_pkg::RSP_W-1:0]  rsp_tdata
);
   import scm_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // out of reset: no result pending, ready for a word
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // a new result is only launched from the busy side, never while taking words
   a_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result raised while input was ready");

   // no word accepted can produce its result in the very next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared directly after an accepted word");

endmodule

bind square_matrix_multiply scm_check u_scm_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
